FILE: design/bpc_pkg.sv
// shared types, constants and helpers for the pressure compensation block
// no dependencies
`default_nettype none
package bpc_pkg;

  localparam int unsigned RawW   = 20;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned DivStages = 32;

  localparam logic [CfgIdxW-1:0] RegTempTrim = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPressLow = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPressHigh = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPressLast = 2'd3;

  localparam logic [31:0] Off64000 = 32'd64000;
  localparam logic [31:0] Off32768 = 32'd32768;
  localparam logic [31:0] Off1M    = 32'd1048576;
  localparam logic [31:0] Mul3125  = 32'd3125;
  localparam logic [31:0] SignBit  = 32'h8000_0000;

  // trim coefficients widened to words: t1 and p1 zero extended, the rest sign extended
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } trim_t;

  // wrapping 32-bit product
  function automatic logic [31:0] mul32(input logic [31:0] x, input logic [31:0] y);
    logic [63:0] r;
    r = x * y;
    return r[31:0];
  endfunction

  function automatic logic [31:0] sra(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

FILE: design/bpc_div.sv
// pipelined restoring divider, one quotient bit per stage, 32-bit unsigned
// depends on bpc_pkg
`default_nettype none
module bpc_div #(
  parameter type side_t = logic
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [31:0] num_i,
  input  wire logic [31:0] den_i,
  input  wire side_t       side_i,
  output logic             valid_o,
  output logic [31:0]      quo_o,
  output side_t            side_o
);
  localparam int unsigned N = bpc_pkg::DivStages;

  // stage registers, entry s holds the beat after s quotient bits
  logic [N:1]       vld_q;
  logic [31:0]      num_q  [1:N];
  logic [31:0]      rem_q  [1:N-1];
  logic [31:0]      den_q  [1:N-1];
  side_t            side_q [1:N];

  // one quotient bit per stage, msb first; quotient shifts into num
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic        vld_s;
    logic [31:0] num_s, rem_s, den_s;
    side_t       side_s;
    logic [32:0] trial_d;
    logic [32:0] rem_d;
    logic        bit_d;

    // stage inputs: the port for the first stage, registers after that
    if (s == 0) begin : g_first
      assign vld_s  = valid_i;
      assign num_s  = num_i;
      assign rem_s  = '0;
      assign den_s  = den_i;
      assign side_s = side_i;
    end else begin : g_next
      assign vld_s  = vld_q[s];
      assign num_s  = num_q[s];
      assign rem_s  = rem_q[s];
      assign den_s  = den_q[s];
      assign side_s = side_q[s];
    end

    always_comb begin
      trial_d = {rem_s, num_s[31]};
      bit_d   = trial_d >= {1'b0, den_s};
      rem_d   = bit_d ? trial_d - {1'b0, den_s} : trial_d;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_s;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1]  <= {num_s[30:0], bit_d};
        side_q[s+1] <= side_s;
      end
    end

    // remainder and divisor only needed by later stages
    if (s < N - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1] <= rem_d[31:0];
          den_q[s+1] <= den_s;
        end
      end
    end
  end

  assign valid_o = vld_q[N];
  assign quo_o   = num_q[N];
  assign side_o  = side_q[N];
endmodule
`default_nettype wire

FILE: design/bpc_front.sv
// front stages: fine temperature and pressure numerator/divisor
// depends on bpc_pkg
`default_nettype none
module bpc_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [19:0]         adc_p_i,
  input  wire logic [19:0]         adc_t_i,
  input  wire bpc_pkg::trim_t      trim_i,
  output logic                     valid_o,
  output logic [31:0]              t_fine_o,
  output logic [31:0]              num_o,
  output logic [31:0]              den_o,
  output logic                     big_o
);
  // stage 1: first products
  logic        v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [31:0] adcp1_q, ta_q, dd_q;
  logic [31:0] adcp2_q, ta2_q, tb2_q;
  logic [31:0] adcp3_q, tf3_q, a3_q, a2_3_q;
  logic [31:0] adcp4_q, tf4_q, a4_q, sq4_q;
  logic [31:0] adcp5_q, tf5_q, sqb5_q, ap5_q, p3s5_q, p2a5_q;
  logic [31:0] tf6_q, b6_q, a6_q;
  logic [31:0] adcp6_q, tf7_q, den7_q, pr7_q;
  logic        v7_q;

  logic [31:0] adc_t32, d1, dd_d;
  always_comb begin
    adc_t32 = {12'd0, adc_t_i};
    d1   = (adc_t32 >> 4) - trim_i.t1;
    dd_d = bpc_pkg::mul32(d1, d1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= '0;
    end else if (en_i) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= {valid_i, v1_q, v2_q, v3_q, v4_q, v5_q};
    end
  end

  // pressure arithmetic staged one multiplier deep
  logic [31:0] a3_d, p3b;
  logic [31:0] a6_d, b6_d, pa1;
  always_comb begin
    a3_d = bpc_pkg::sra(ta2_q + tb2_q, 1) - bpc_pkg::Off64000;
    b6_d = bpc_pkg::sra(sqb5_q + (ap5_q << 1), 2) + (trim_i.p4 << 16);
    p3b  = bpc_pkg::sra(bpc_pkg::sra(p3s5_q, 3) + bpc_pkg::sra(p2a5_q, 1), 18);
    a6_d = bpc_pkg::Off32768 + p3b;
    pa1  = bpc_pkg::mul32(a6_q, trim_i.p1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adcp1_q <= {12'd0, adc_p_i};
      ta_q    <= bpc_pkg::mul32((adc_t32 >> 3) - (trim_i.t1 << 1), trim_i.t2);
      dd_q    <= dd_d;
      adcp2_q <= adcp1_q;
      ta2_q   <= bpc_pkg::sra(ta_q, 11);
      tb2_q   <= bpc_pkg::sra(bpc_pkg::mul32(bpc_pkg::sra(dd_q, 12), trim_i.t3), 14);
      adcp3_q <= adcp2_q;
      tf3_q   <= ta2_q + tb2_q;
      a3_q    <= a3_d;
      a2_3_q  <= bpc_pkg::sra(a3_d, 2);
      adcp4_q <= adcp3_q;
      tf4_q   <= tf3_q;
      a4_q    <= a3_q;
      sq4_q   <= bpc_pkg::mul32(a2_3_q, a2_3_q);
      adcp5_q <= adcp4_q;
      tf5_q   <= tf4_q;
      sqb5_q  <= bpc_pkg::mul32(bpc_pkg::sra(sq4_q, 11), trim_i.p6);
      ap5_q   <= bpc_pkg::mul32(a4_q, trim_i.p5);
      p3s5_q  <= bpc_pkg::mul32(trim_i.p3, bpc_pkg::sra(sq4_q, 13));
      p2a5_q  <= bpc_pkg::mul32(trim_i.p2, a4_q);
      tf6_q   <= tf5_q;
      b6_q    <= b6_d;
      a6_q    <= a6_d;
      adcp6_q <= adcp5_q;
      tf7_q   <= tf6_q;
      den7_q  <= bpc_pkg::sra(pa1, 15);
      pr7_q   <= bpc_pkg::mul32((bpc_pkg::Off1M - adcp6_q) - bpc_pkg::sra(b6_q, 12),
                                bpc_pkg::Mul3125);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en_i) begin
      v7_q <= v6_q;
    end
  end

  assign valid_o  = v7_q;
  assign t_fine_o = tf7_q;
  assign den_o    = den7_q;
  assign big_o    = pr7_q >= bpc_pkg::SignBit;
  assign num_o    = big_o ? pr7_q : (pr7_q << 1);
endmodule
`default_nettype wire

FILE: design/bpc_back.sv
// back stages: final pressure correction after the divide
// depends on bpc_pkg
`default_nettype none
module bpc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [31:0]    quo_i,
  input  wire logic           big_i,
  input  wire logic           fault_i,
  input  wire logic [31:0]    t_fine_i,
  input  wire bpc_pkg::trim_t trim_i,
  output logic                valid_o,
  output logic [31:0]         press_o,
  output logic [31:0]         t_fine_o,
  output logic                fault_o
);
  logic        v1_q, v2_q, v3_q, v4_q;
  logic [31:0] p1_q, p2_q, p3_q, p4_q;
  logic [31:0] sq2_q, a3_q, b2_q, b3_q, sum4_q;
  logic [31:0] tf1_q, tf2_q, tf3_q, tf4_q;
  logic        f1_q, f2_q, f3_q, f4_q;

  logic [31:0] p_d;
  assign p_d = big_i ? (quo_i << 1) : quo_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q} <= '0;
    end else if (en_i) begin
      {v1_q, v2_q, v3_q, v4_q} <= {valid_i, v1_q, v2_q, v3_q};
    end
  end

  // p*p and the p8 product, then the p9 product, then the sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= p_d;
      tf1_q <= t_fine_i;
      f1_q  <= fault_i;
      p2_q  <= p1_q;
      tf2_q <= tf1_q;
      f2_q  <= f1_q;
      sq2_q <= bpc_pkg::mul32(p1_q >> 3, p1_q >> 3) >> 13;
      b2_q  <= bpc_pkg::sra(bpc_pkg::mul32(p1_q >> 2, trim_i.p8), 13);
      p3_q  <= p2_q;
      tf3_q <= tf2_q;
      f3_q  <= f2_q;
      a3_q  <= bpc_pkg::sra(bpc_pkg::mul32(trim_i.p9, sq2_q), 12);
      b3_q  <= b2_q;
      p4_q  <= p3_q;
      tf4_q <= tf3_q;
      f4_q  <= f3_q;
      sum4_q <= bpc_pkg::sra(a3_q + b3_q + trim_i.p7, 4);
    end
  end

  assign valid_o  = v4_q;
  assign press_o  = f4_q ? '0 : p4_q + sum4_q;
  assign t_fine_o = tf4_q;
  assign fault_o  = f4_q;
endmodule
`default_nettype wire

FILE: design/barometric_pressure_compensation_top.sv
// top level: config registers, pipeline, output register
// depends on bpc_pkg, bpc_front, bpc_div, bpc_back
//
// channel  | dir | payload
// s_axis   | in  | tdata[19:0] raw_pressure, [39:20] raw_temperature
// m_axis   | out | tdata[31:0] pressure_pa, [63:32] fine_temperature, tuser divide_fault
// cfg      | in  | cfg_index_i register, cfg_data_i value
//
// one beat per cycle sustained while m_axis accepts; stages: 7 front stages, 32 divider
// stages (one quotient bit each), 4 back stages and the output register.
// reset clears valid bits and trim registers; whole pipeline advances together.
// a stall on m_axis freezes the pipeline only while a result is held and the
// output stage is full, so no beat is lost or repeated.
`default_nettype none
module barometric_pressure_compensation_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // raw_pressure, raw_temperature
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // pressure_pa, fine_temperature
  output logic             m_axis_tuser,  // divide_fault
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  // trim registers
  logic [47:0] temp_q;
  logic [63:0] plow_q, phigh_q;
  logic [15:0] plast_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0; plow_q <= '0; phigh_q <= '0; plast_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bpc_pkg::RegTempTrim:  temp_q  <= cfg_data_i[47:0];
        bpc_pkg::RegPressLow:  plow_q  <= cfg_data_i;
        bpc_pkg::RegPressHigh: phigh_q <= cfg_data_i;
        bpc_pkg::RegPressLast: plast_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  bpc_pkg::trim_t trim;
  always_comb begin
    trim.t1 = {16'd0, temp_q[15:0]};
    trim.t2 = bpc_pkg::sx16(temp_q[31:16]);
    trim.t3 = bpc_pkg::sx16(temp_q[47:32]);
    trim.p1 = {16'd0, plow_q[15:0]};
    trim.p2 = bpc_pkg::sx16(plow_q[31:16]);
    trim.p3 = bpc_pkg::sx16(plow_q[47:32]);
    trim.p4 = bpc_pkg::sx16(plow_q[63:48]);
    trim.p5 = bpc_pkg::sx16(phigh_q[15:0]);
    trim.p6 = bpc_pkg::sx16(phigh_q[31:16]);
    trim.p7 = bpc_pkg::sx16(phigh_q[47:32]);
    trim.p8 = bpc_pkg::sx16(phigh_q[63:48]);
    trim.p9 = bpc_pkg::sx16(plast_q);
  end

  // pipeline advances unless a finished beat is stuck at the output
  logic en, out_v_q;
  logic [63:0] out_d_q;
  logic        out_u_q;
  logic        bk_v;
  logic [31:0] bk_p, bk_tf;
  logic        bk_f;
  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  logic        fr_v, fr_big;
  logic [31:0] fr_tf, fr_num, fr_den;
  bpc_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid),
    .adc_p_i(s_axis_tdata[19:0]), .adc_t_i(s_axis_tdata[39:20]), .trim_i(trim),
    .valid_o(fr_v), .t_fine_o(fr_tf), .num_o(fr_num), .den_o(fr_den), .big_o(fr_big)
  );

  typedef struct packed {
    logic [31:0] tf;
    logic        big;
    logic        fault;
  } side_t;
  side_t side_in, side_out;
  logic        dv_v;
  logic [31:0] dv_q;
  assign side_in = '{tf: fr_tf, big: fr_big, fault: fr_den == '0};

  bpc_div #(.side_t(side_t)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fr_v), .num_i(fr_num),
    .den_i(fr_den == '0 ? 32'd1 : fr_den), .side_i(side_in),
    .valid_o(dv_v), .quo_o(dv_q), .side_o(side_out)
  );

  bpc_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv_v), .quo_i(dv_q), .big_i(side_out.big),
    .fault_i(side_out.fault), .t_fine_i(side_out.tf), .trim_i(trim),
    .valid_o(bk_v), .press_o(bk_p), .t_fine_o(bk_tf), .fault_o(bk_f)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= bk_v;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_d_q <= {bk_tf, bk_p};
      out_u_q <= bk_f;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_d_q;
  assign m_axis_tuser  = out_u_q;
endmodule
`default_nettype wire

FILE: verif/bpc_checker.sv
// result checker for the pressure compensation block: watches all channels,
// predicts each result from the trim registers and compares in order
// depends on bpc_pkg for register indexes and constants
`timescale 1ns / 100ps
`default_nettype none
module bpc_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // raw_pressure, raw_temperature
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [63:0] m_axis_tdata,  // pressure_pa, fine_temperature
  input  wire logic        m_axis_tuser,  // divide_fault
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  typedef struct packed {
    logic [31:0] pressure;
    logic [31:0] t_fine;
    logic        fault;
  } comp_result_t;

  logic [47:0] temp_trim_q;
  logic [63:0] press_low_q, press_high_q;
  logic [15:0] press_last_q;
  comp_result_t expected_q[$];

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] sext(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // 32-bit integer compensation, every step wrapping
  function automatic comp_result_t compensate(input logic [19:0] adc_p,
                                              input logic [19:0] adc_t);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] ap, at, a, b, d, tf, p, sq;
    comp_result_t r;
    ap = {12'd0, adc_p};
    at = {12'd0, adc_t};
    t1 = {16'd0, temp_trim_q[15:0]};
    t2 = sext(temp_trim_q[31:16]);
    t3 = sext(temp_trim_q[47:32]);
    p1 = {16'd0, press_low_q[15:0]};
    p2 = sext(press_low_q[31:16]);
    p3 = sext(press_low_q[47:32]);
    p4 = sext(press_low_q[63:48]);
    p5 = sext(press_high_q[15:0]);
    p6 = sext(press_high_q[31:16]);
    p7 = sext(press_high_q[47:32]);
    p8 = sext(press_high_q[63:48]);
    p9 = sext(press_last_q);
    // temperature
    a = asr(32'(((at >> 3) - (t1 << 1)) * t2), 11);
    d = (at >> 4) - t1;
    b = asr(32'(asr(32'(d * d), 12) * t3), 14);
    tf = a + b;
    // pressure
    a = asr(tf, 1) - bpc_pkg::Off64000;
    sq = 32'(asr(a, 2) * asr(a, 2));
    b = 32'(asr(sq, 11) * p6);
    b = b + 32'(32'(a * p5) << 1);
    b = asr(b, 2) + (p4 << 16);
    a = asr(asr(32'(p3 * asr(sq, 13)), 3) + asr(32'(p2 * a), 1), 18);
    a = asr(32'((bpc_pkg::Off32768 + a) * p1), 15);
    r.t_fine = tf;
    if (a == 0) begin
      r.pressure = '0;
      r.fault = 1'b1;
    end else begin
      p = 32'(((bpc_pkg::Off1M - ap) - asr(b, 12)) * bpc_pkg::Mul3125);
      if (p < bpc_pkg::SignBit) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      a = asr(32'(p9 * ((32'((p >> 3) * (p >> 3))) >> 13)), 12);
      b = asr(32'((p >> 2) * p8), 13);
      r.pressure = p + asr(a + b + p7, 4);
      r.fault = 1'b0;
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  // trim register shadow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q <= '0;
      press_low_q <= '0;
      press_high_q <= '0;
      press_last_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bpc_pkg::RegTempTrim: temp_trim_q <= cfg_data_i[47:0];
        bpc_pkg::RegPressLow: press_low_q <= cfg_data_i;
        bpc_pkg::RegPressHigh: press_high_q <= cfg_data_i;
        bpc_pkg::RegPressLast: press_last_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    comp_result_t got, want;
    int errs;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      errs = 0;
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(compensate(s_axis_tdata[19:0], s_axis_tdata[39:20]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (got.pressure !== want.pressure) begin
            $display("%0t: pressure_pa expected %h actual %h", $time,
                     want.pressure, got.pressure);
            errs++;
          end
          if (got.t_fine !== want.t_fine) begin
            $display("%0t: fine_temperature expected %h actual %h", $time,
                     want.t_fine, got.t_fine);
            errs++;
          end
          if (got.fault !== want.fault) begin
            $display("%0t: divide_fault expected %b actual %b", $time,
                     want.fault, got.fault);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end
endmodule
`default_nettype wire

FILE: verif/tb_barometric_pressure_compensation_top.sv
// testbench top for the pressure compensation block: clock, reset, trim
// settings, raw sample stimulus and verdict; checking lives in bpc_checker
`timescale 1ns / 100ps
`default_nettype none
module tb_barometric_pressure_compensation_top;
  localparam int Latency = 44;
  localparam int CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  int fail_count, pending;
  int cycles = 0;
  bit calm = 1'b0;      // no idling on either side
  int hold_off = 0;     // receiver stall length request

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  barometric_pressure_compensation_top dut (.*);

  bpc_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 33);
    end
  end

  // one register write, then the channel is left quiet before returning
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // valid stays up after the beat; an idle gap before the next beat, or drain, lowers it
  task automatic send_sample(input logic [19:0] adc_p, input logic [19:0] adc_t);
    while (!calm && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {adc_t, adc_p};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // plausible factory trims with random scatter
  task automatic load_typical_trims();
    logic [15:0] t1, p1;
    t1 = 16'd27504 + 16'($urandom_range(2000));
    p1 = 16'd36477 + 16'($urandom_range(4000));
    write_reg(bpc_pkg::RegTempTrim, {16'd0, 16'(-16'sd1000 + $urandom_range(100)),
                                     16'd26435, t1});
    write_reg(bpc_pkg::RegPressLow, {16'd2855, 16'(16'sd3024 + $urandom_range(50)),
                                     16'(-16'sd10685), p1});
    write_reg(bpc_pkg::RegPressHigh, {16'(-16'sd14600), 16'd15500, 16'(-16'sd7),
                                      16'd140});
    write_reg(bpc_pkg::RegPressLast, 64'd6000);
  endtask

  task automatic load_random_trims();
    write_reg(bpc_pkg::RegTempTrim, {$urandom, $urandom});
    write_reg(bpc_pkg::RegPressLow, {$urandom, $urandom});
    write_reg(bpc_pkg::RegPressHigh, {$urandom, $urandom});
    write_reg(bpc_pkg::RegPressLast, {$urandom, $urandom});
  endtask

  task automatic random_burst(input int count);
    for (int i = 0; i < count; i++)
      send_sample(20'($urandom), 20'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero trims: divisor is zero, pressure forced to 0
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();

    // typical trims with extreme and typical raw values
    load_typical_trims();
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'd0);
    send_sample(20'd415148, 20'd519888);
    send_sample(20'h55555, 20'hAAAAA);
    send_sample(20'hAAAAA, 20'h55555);
    drain();

    // extreme trims: every field at its top, then at its bottom, with p1 at 1
    write_reg(bpc_pkg::RegTempTrim, {16'h7FFF, 16'h7FFF, 16'hFFFF});
    write_reg(bpc_pkg::RegPressLow, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF});
    write_reg(bpc_pkg::RegPressHigh, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    write_reg(bpc_pkg::RegPressLast, 64'h7FFF);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'd0);
    drain();
    write_reg(bpc_pkg::RegTempTrim, {16'h8000, 16'h8000, 16'h0000});
    write_reg(bpc_pkg::RegPressLow, {16'h8000, 16'h8000, 16'h8000, 16'h0001});
    write_reg(bpc_pkg::RegPressHigh, {16'h8000, 16'h8000, 16'h8000, 16'h8000});
    write_reg(bpc_pkg::RegPressLast, 64'hFFFF_FFFF_FFFF_8000);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'd0);
    drain();

    // long receiver hold-off while the sender keeps offering
    load_typical_trims();
    hold_off = 120;
    calm = 1'b1;
    random_burst(80);
    calm = 1'b0;
    drain();

    // random phases, mostly realistic trims, some fully random
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) load_random_trims();
      else load_typical_trims();
      calm = (ph == 4);
      random_burst(55);
      calm = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: barometric_pressure_compensation_top.f
design/bpc_pkg.sv
design/bpc_div.sv
design/bpc_front.sv
design/bpc_back.sv
design/barometric_pressure_compensation_top.sv
verif/bpc_checker.sv
verif/tb_barometric_pressure_compensation_top.sv
